/* hdl/utr_pkg.sv */
// shared constants, types and the arctangent table for the unicycle rollout
`timescale 1ns / 1ps

package utr_pkg;

  // default sizing
  localparam int unsigned MaxStepsDef    = 64;
  localparam int unsigned CordicItersDef = 16;
  localparam int unsigned AtanEntries    = 24;

  // field widths
  localparam int unsigned CmdW     = 16;
  localparam int unsigned DtW      = 16;
  localparam int unsigned CountW   = 7;
  localparam int unsigned PosW     = 32;
  localparam int unsigned HeadW    = 25;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // datapath widths
  localparam int unsigned TrigW  = 34;                  // cordic x, y, z (Q2.30 plus guard)
  localparam int unsigned MulAW  = 34;
  localparam int unsigned MulBW  = 18;
  localparam int unsigned MulPW  = MulAW + MulBW;
  localparam int unsigned DeltaW = 22;                  // per-step increments
  localparam int unsigned RedW   = 27;                  // angle reduction register

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTimeStep  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegStepCount = 1'd1;

  localparam logic [DtW-1:0]    TimeStepRst  = 16'd3277;
  localparam logic [CountW-1:0] StepCountRst = 7'd20;

  // angle constants in Q8.16
  localparam logic signed [RedW-1:0] TwoPi      = 27'sd411775;
  localparam logic signed [RedW-1:0] Pi         = 27'sd205887;
  localparam logic signed [RedW-1:0] HalfPi     = 27'sd102944;
  // 41 turns lift any saturated heading above zero
  localparam logic signed [RedW-1:0] TurnOffset = 27'sd16882775;
  localparam logic signed [TrigW-1:0] GainInv   = 34'sh026DD3B6A;

  localparam logic signed [HeadW:0] HeadMax = 26'sd16777215;
  localparam logic signed [HeadW:0] HeadMin = -26'sd16777216;

  typedef struct packed {
    logic                    start;
    logic signed [HeadW-1:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [TrigW-1:0] cos_v;
    logic signed [TrigW-1:0] sin_v;
  } trig_rsp_t;

  // truncated atan(2^-i) in Q2.30
  function automatic logic signed [TrigW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [TrigW-1:0] v;
    unique case (idx)
      5'd0:    v = 34'sh03243F6A8;
      5'd1:    v = 34'sh01DAC6705;
      5'd2:    v = 34'sh00FADBAFC;
      5'd3:    v = 34'sh007F56EA6;
      5'd4:    v = 34'sh003FEAB76;
      5'd5:    v = 34'sh001FFD55B;
      5'd6:    v = 34'sh000FFFAAA;
      5'd7:    v = 34'sh0007FFF55;
      5'd8:    v = 34'sh0003FFFEA;
      5'd9:    v = 34'sh0001FFFFD;
      5'd10:   v = 34'sh0000FFFFF;
      5'd11:   v = 34'sh00007FFFF;
      5'd12:   v = 34'sh00003FFFF;
      5'd13:   v = 34'sh00001FFFF;
      5'd14:   v = 34'sh00000FFFF;
      5'd15:   v = 34'sh000007FFF;
      5'd16:   v = 34'sh000003FFF;
      5'd17:   v = 34'sh000001FFF;
      5'd18:   v = 34'sh000000FFF;
      5'd19:   v = 34'sh0000007FF;
      5'd20:   v = 34'sh0000003FF;
      5'd21:   v = 34'sh0000001FF;
      5'd22:   v = 34'sh0000000FF;
      5'd23:   v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/unicycle_trajectory_rollout.sv */
// unicycle rollout: step sequencer, accumulators, config registers and output register
// per command: turn_rate*dt and speed*dt through the shared multiplier; per point:
//   heading add, 7 reduction steps, fold, one cordic iteration per cycle, the cos
//   and sin partial products, then emit, which waits while the output is stalled
// a new command is taken only when idle, after the last point of the previous one
// reset: asynchronous active low, time_step to 3277 and step_count to 20, block idle
`timescale 1ns / 1ps

module unicycle_trajectory_rollout #(
  parameter int unsigned MAX_STEPS    = utr_pkg::MaxStepsDef,
  parameter int unsigned CORDIC_ITERS = utr_pkg::CordicItersDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [utr_pkg::CmdW-1:0]       speed_i,
  input  logic signed [utr_pkg::CmdW-1:0]       turn_rate_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [utr_pkg::PosW-1:0]       pos_x_o,
  output logic signed [utr_pkg::PosW-1:0]       pos_y_o,
  output logic signed [utr_pkg::HeadW-1:0]      heading_o,
  output logic                                  last_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [utr_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [utr_pkg::CfgDataW-1:0]          cfg_data_i
);

  localparam int unsigned CntW = (MAX_STEPS < 2) ? 1 : $clog2(MAX_STEPS + 1);
  localparam int unsigned AW   = utr_pkg::MulAW;
  localparam int unsigned BW   = utr_pkg::MulBW;
  localparam int unsigned PW   = utr_pkg::MulPW;
  localparam int unsigned DW   = utr_pkg::DeltaW;
  localparam int unsigned HW   = utr_pkg::HeadW;
  localparam int unsigned XW   = utr_pkg::PosW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_HEAD,
    ST_TRIG,
    ST_MUL,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [2:0]             phase_q;
  logic [utr_pkg::DtW-1:0]    time_step_q;
  logic [utr_pkg::CountW-1:0] step_count_q;
  logic [CntW-1:0]        limit_q, step_q;
  logic signed [utr_pkg::CmdW-1:0] speed_q, turn_q;
  logic signed [AW-1:0]   sd_q;
  logic signed [DW-1:0]   dh_q, dx_q, dy_q;
  logic signed [PW-1:0]   acc_q;
  logic signed [HW-1:0]   heading_q;
  logic                   hchg_q;
  logic signed [XW-1:0]   x_q, y_q;

  logic                   out_valid_q;
  logic signed [XW-1:0]   pos_x_q, pos_y_q;
  logic signed [HW-1:0]   heading_out_q;
  logic                   last_q;

  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   prod;
  logic signed [63:0]     wide_sum;
  logic signed [DW-1:0]   delta_rnd;
  logic signed [PW-1:0]   dh_sum;
  logic signed [HW:0]     hsum;
  logic signed [HW-1:0]   hsat;
  logic [CntW-1:0]        step_nxt;
  logic [CntW-1:0]        limit_nxt;
  logic                   is_last;
  logic                   slot_free;
  logic                   in_acc;

  utr_pkg::trig_req_t     trig_req;
  utr_pkg::trig_rsp_t     trig_rsp;

  utr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  utr_sincos #(
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (trig_req),
    .rsp_o  (trig_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = sd_q;
    mul_b = '0;
    if (state_q == ST_PRE) begin
      mul_a = (phase_q == 3'd0) ? AW'(turn_q) : AW'(speed_q);
      mul_b = BW'(time_step_q);
    end else begin
      unique case (phase_q)
        3'd0:    mul_b = BW'(trig_rsp.cos_v[15:0]);
        3'd1:    mul_b = trig_rsp.cos_v[AW-1:16];
        3'd2:    mul_b = BW'(trig_rsp.sin_v[15:0]);
        3'd3:    mul_b = trig_rsp.sin_v[AW-1:16];
        default: mul_b = '0;
      endcase
    end
  end

  // rebuild speed*dt*trig from two partial products and round off 42 bits
  assign wide_sum  = (64'(prod) <<< 16) + 64'(acc_q) + (64'sd1 <<< 41);
  assign delta_rnd = wide_sum[63:42];
  assign dh_sum    = prod + PW'(2048);

  always_comb begin
    hsum = (HW+1)'(heading_q) + (HW+1)'(dh_q);
    if (hsum > utr_pkg::HeadMax) begin
      hsat = HW'(utr_pkg::HeadMax);
    end else if (hsum < utr_pkg::HeadMin) begin
      hsat = HW'(utr_pkg::HeadMin);
    end else begin
      hsat = hsum[HW-1:0];
    end
  end

  assign trig_req.start = (state_q == ST_HEAD);
  assign trig_req.angle = hsat;

  always_comb begin
    if (step_count_q == '0) begin
      limit_nxt = CntW'(1);
    end else if (step_count_q > utr_pkg::CountW'(MAX_STEPS)) begin
      limit_nxt = CntW'(MAX_STEPS);
    end else begin
      limit_nxt = step_count_q[CntW-1:0];
    end
  end

  assign step_nxt = step_q + CntW'(1);
  assign is_last  = (step_nxt >= limit_q) ||
                    (dx_q == '0 && dy_q == '0 && !hchg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= '0;
      time_step_q   <= utr_pkg::TimeStepRst;
      step_count_q  <= utr_pkg::StepCountRst;
      out_valid_q   <= 1'b0;
      limit_q       <= '0;
      step_q        <= '0;
      speed_q       <= '0;
      turn_q        <= '0;
      sd_q          <= '0;
      dh_q          <= '0;
      dx_q          <= '0;
      dy_q          <= '0;
      acc_q         <= '0;
      heading_q     <= '0;
      hchg_q        <= 1'b0;
      x_q           <= '0;
      y_q           <= '0;
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      heading_out_q <= '0;
      last_q        <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          utr_pkg::RegTimeStep:  time_step_q  <= cfg_data_i;
          utr_pkg::RegStepCount: step_count_q <= cfg_data_i[utr_pkg::CountW-1:0];
          default: ;
        endcase
      end

      // the emit state loads the next point itself
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            speed_q   <= speed_i;
            turn_q    <= turn_rate_i;
            limit_q   <= limit_nxt;
            step_q    <= '0;
            x_q       <= '0;
            y_q       <= '0;
            heading_q <= '0;
            phase_q   <= '0;
            state_q   <= ST_PRE;
          end
        end
        ST_PRE: begin
          phase_q <= phase_q + 3'd1;
          if (phase_q == 3'd1) begin
            dh_q <= dh_sum[DW+11:12];
          end
          if (phase_q == 3'd2) begin
            sd_q    <= prod[AW-1:0];
            state_q <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          hchg_q    <= (hsat != heading_q);
          heading_q <= hsat;
          state_q   <= ST_TRIG;
        end
        ST_TRIG: begin
          if (trig_rsp.done) begin
            phase_q <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          phase_q <= phase_q + 3'd1;
          unique case (phase_q)
            3'd1, 3'd3: acc_q <= prod;
            3'd2:       dx_q  <= delta_rnd;
            3'd4: begin
              dy_q    <= delta_rnd;
              state_q <= ST_EMIT;
            end
            default: ;
          endcase
        end
        ST_EMIT: begin
          if (slot_free) begin
            x_q           <= x_q + XW'(dx_q);
            y_q           <= y_q + XW'(dy_q);
            step_q        <= step_nxt;
            out_valid_q   <= 1'b1;
            pos_x_q       <= x_q + XW'(dx_q);
            pos_y_q       <= y_q + XW'(dy_q);
            heading_out_q <= heading_q;
            last_q        <= is_last;
            state_q       <= is_last ? ST_IDLE : ST_HEAD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign heading_o   = heading_out_q;
  assign last_o      = last_q;

endmodule

/* hdl/utr_mul.sv */
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module utr_mul (
  input  logic                              clk_i,
  input  logic signed [utr_pkg::MulAW-1:0]  a_i,
  input  logic signed [utr_pkg::MulBW-1:0]  b_i,
  output logic signed [utr_pkg::MulPW-1:0]  p_o
);

  logic signed [utr_pkg::MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= utr_pkg::MulPW'(a_i) * utr_pkg::MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

/* hdl/utr_sincos.sv */
// heading reduction and iterative cordic for cosine and sine
`timescale 1ns / 1ps

module utr_sincos #(
  parameter int unsigned CORDIC_ITERS = utr_pkg::CordicItersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utr_pkg::trig_req_t  req_i,
  output utr_pkg::trig_rsp_t  rsp_o
);

  localparam int unsigned Iters = (CORDIC_ITERS > utr_pkg::AtanEntries) ?
                                  utr_pkg::AtanEntries : CORDIC_ITERS;
  localparam logic [4:0] LastIter = 5'(Iters - 1);
  localparam int unsigned RW = utr_pkg::RedW;
  localparam int unsigned TW = utr_pkg::TrigW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FOLD,
    ST_ROTATE
  } state_e;

  state_e                state_q;
  logic [2:0]            k_q;
  logic [4:0]            i_q;
  logic                  flip_q;
  logic                  done_q;
  logic signed [RW-1:0]  r_q;
  logic signed [TW-1:0]  x_q, y_q, z_q;

  logic signed [RW-1:0]  modulus;
  logic signed [RW-1:0]  rc;
  logic signed [RW-1:0]  rf;
  logic                  fold;
  logic signed [TW-1:0]  xs, ys, at;

  // one restoring step against 2*pi scaled by 2^k
  assign modulus = utr_pkg::TwoPi <<< k_q;

  always_comb begin
    rc   = (r_q > utr_pkg::Pi) ? r_q - utr_pkg::TwoPi : r_q;
    fold = 1'b0;
    rf   = rc;
    if (rc > utr_pkg::HalfPi) begin
      rf   = rc - utr_pkg::Pi;
      fold = 1'b1;
    end else if (rc < -utr_pkg::HalfPi) begin
      rf   = rc + utr_pkg::Pi;
      fold = 1'b1;
    end
  end

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = utr_pkg::atan_q30(i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
      i_q     <= '0;
      flip_q  <= 1'b0;
      r_q     <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
    end else begin
      done_q <= (state_q == ST_ROTATE) && (i_q == LastIter);
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            r_q     <= RW'(req_i.angle) + utr_pkg::TurnOffset;
            k_q     <= 3'd6;
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (r_q >= modulus) begin
            r_q <= r_q - modulus;
          end
          if (k_q == 3'd0) begin
            state_q <= ST_FOLD;
          end else begin
            k_q <= k_q - 3'd1;
          end
        end
        ST_FOLD: begin
          flip_q  <= fold;
          z_q     <= TW'(rf) <<< 14;
          x_q     <= utr_pkg::GainInv;
          y_q     <= '0;
          i_q     <= '0;
          state_q <= ST_ROTATE;
        end
        ST_ROTATE: begin
          if (!z_q[TW-1]) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end
          if (i_q == LastIter) begin
            state_q <= ST_IDLE;
          end else begin
            i_q <= i_q + 5'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = flip_q ? -x_q : x_q;
  assign rsp_o.sin_v = flip_q ? -y_q : y_q;

endmodule

/* tb/tb.sv */
// self-checking testbench for the unicycle trajectory rollout block
`timescale 1ns / 1ps

module tb;

  localparam int MaxSteps    = utr_pkg::MaxStepsDef;
  localparam int CordicIters = utr_pkg::CordicItersDef;
  localparam int AtanCount   = 24;
  localparam int TwoPiQ16    = 411775;
  localparam int PiQ16       = 205887;
  localparam int HalfPiQ16   = 102944;
  localparam longint CordicStart = 64'sh26DD3B6A;
  localparam int HeadingTop  = 16777215;
  localparam int HeadingBot  = -16777216;
  localparam int IdlePct     = 18;
  localparam int CycleLimit  = 6000000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [24:0] hdg;
    logic        last;
  } traj_point_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [utr_pkg::CmdW-1:0] speed_i;
  logic signed [utr_pkg::CmdW-1:0] turn_rate_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [utr_pkg::PosW-1:0] pos_x_o;
  logic signed [utr_pkg::PosW-1:0] pos_y_o;
  logic signed [utr_pkg::HeadW-1:0] heading_o;
  logic last_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [utr_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [utr_pkg::CfgDataW-1:0] cfg_data_i;

  // truncated atan(2^-i) in Q2.30
  longint atan_steps [AtanCount] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  traj_point_t expected_points[$];
  int dt_q16 = 3277;
  int points_per_cmd = 20;
  int mismatches = 0;
  int cycle_cnt = 0;
  bit calm = 1'b0;

  unicycle_trajectory_rollout u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .speed_i     (speed_i),
    .turn_rate_i (turn_rate_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .heading_o   (heading_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // cosine and sine of a Q8.16 heading, both Q2.30
  function automatic void heading_trig(input int ang, output longint cos_q30,
                                       output longint sin_q30);
    int r;
    bit flip;
    longint x, y, z, nx;
    int i;
    flip = 1'b0;
    r = ang % TwoPiQ16;
    if (r < 0) r += TwoPiQ16;
    if (r > PiQ16) r -= TwoPiQ16;
    if (r > HalfPiQ16) begin
      r -= PiQ16;
      flip = 1'b1;
    end else if (r < -HalfPiQ16) begin
      r += PiQ16;
      flip = 1'b1;
    end
    x = CordicStart;
    y = 0;
    z = longint'(r) * 16384;
    for (i = 0; i < CordicIters && i < AtanCount; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_steps[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_steps[i];
      end
      x = nx;
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  // euler rollout of one command from the origin, queues every point it emits
  function automatic void roll_out_cmd(input logic signed [15:0] spd,
                                       input logic signed [15:0] trn);
    int steps, k, hdg, old_hdg;
    longint dh, h, c, s, dx, dy;
    logic [31:0] px, py;
    traj_point_t pt;
    bit done;
    steps = points_per_cmd;
    if (steps == 0) steps = 1;
    if (steps > MaxSteps) steps = MaxSteps;
    px = '0;
    py = '0;
    hdg = 0;
    k = 0;
    done = 1'b0;
    while (!done) begin
      old_hdg = hdg;
      dh = (longint'(trn) * longint'(dt_q16) + 2048) >>> 12;
      h = longint'(hdg) + dh;
      if (h > HeadingTop) h = HeadingTop;
      if (h < HeadingBot) h = HeadingBot;
      hdg = int'(h);
      heading_trig(hdg, c, s);
      dx = (longint'(spd) * c * longint'(dt_q16) + (longint'(1) << 41)) >>> 42;
      dy = (longint'(spd) * s * longint'(dt_q16) + (longint'(1) << 41)) >>> 42;
      px = px + dx[31:0];
      py = py + dy[31:0];
      k++;
      done = (k >= steps) || (dx[31:0] == 0 && dy[31:0] == 0 && hdg == old_hdg);
      pt.x = px;
      pt.y = py;
      pt.hdg = hdg[24:0];
      pt.last = done;
      expected_points.insert(expected_points.size(), pt);
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endtask

  // result checker and output stall generator
  always @(posedge clk_i) begin
    traj_point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        note_mismatch("unexpected point x", '0, pos_x_o);
      end else begin
        want = expected_points.pop_front();
        if (pos_x_o !== want.x) note_mismatch("pos_x", want.x, pos_x_o);
        if (pos_y_o !== want.y) note_mismatch("pos_y", want.y, pos_y_o);
        if (heading_o !== want.hdg) note_mismatch("heading", 32'(want.hdg), 32'(heading_o));
        if (last_o !== want.last) note_mismatch("last", 32'(want.last), 32'(last_o));
      end
    end
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < IdlePct);
  end

  // one command transaction; valid stays high when the next one follows at once
  task automatic send_cmd(input logic signed [15:0] spd, input logic signed [15:0] trn);
    in_valid_i <= 1'b1;
    speed_i <= spd;
    turn_rate_i <= trn;
    do @(posedge clk_i); while (in_stall_o);
    roll_out_cmd(spd, trn);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
  endtask

  // both registers back to back, only while the block is idle
  task automatic write_config(input int dt, input int cnt);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= utr_pkg::RegTimeStep;
    cfg_data_i <= dt[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= utr_pkg::RegStepCount;
    cfg_data_i <= 16'(cnt[6:0]);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dt_q16 = dt & 32'hFFFF;
    points_per_cmd = cnt & 32'h7F;
  endtask

  task automatic test_field_extremes();
    send_cmd(16'sd0, 16'sd0);
    send_cmd(16'sd32767, 16'sd0);
    send_cmd(-16'sd32768, 16'sd0);
    send_cmd(16'sd0, 16'sd32767);
    send_cmd(16'sd0, -16'sd32768);
    send_cmd(16'sd32767, 16'sd32767);
    send_cmd(-16'sd32768, -16'sd32768);
    send_cmd(16'sd32767, -16'sd32768);
    send_cmd(-16'sd32768, 16'sd32767);
    send_cmd(16'sd1, 16'sd0);
    send_cmd(-16'sd1, 16'sd1);
    send_cmd(16'sd4096, 16'sd4096);
  endtask

  // long horizon with the largest step drives the heading into both clamps
  task automatic test_heading_saturation();
    write_config(65535, 64);
    send_cmd(16'sd0, 16'sd32767);
    send_cmd(16'sd0, -16'sd32768);
    send_cmd(16'sd32767, 16'sd32767);
  endtask

  task automatic test_zero_time_step();
    write_config(0, 5);
    send_cmd(16'sd32767, 16'sd32767);
    send_cmd(-16'sd5, 16'sd7);
  endtask

  task automatic test_step_count_limits();
    write_config(3277, 0);
    send_cmd(16'sd100, 16'sd200);
    write_config(3277, 100);
    send_cmd(16'sd32767, -16'sd32768);
    write_config(1, 127);
    send_cmd(16'sd32767, 16'sd32767);
    send_cmd(16'sd1, 16'sd1);
  endtask

  task automatic random_phase(input int dt, input int cnt, input int n);
    logic signed [15:0] spd, trn;
    int i;
    write_config(dt, cnt);
    for (i = 0; i < n; i++) begin
      spd = 16'($urandom);
      trn = 16'($urandom);
      case ($urandom_range(9))
        0: begin
          // near zero, often stops early
          spd = 16'($urandom_range(32)) - 16'd16;
          trn = 16'($urandom_range(32)) - 16'd16;
        end
        1: spd = '0;
        2: trn = '0;
        3: spd = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
        4: trn = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
        default: ;
      endcase
      send_cmd(spd, trn);
    end
  endtask

  task automatic test_random_rollouts();
    calm = 1'b1;
    random_phase(3277, 20, 60);
    calm = 1'b0;
    random_phase(65535, 64, 20);
    random_phase(1, 1, 40);
    random_phase(0, 10, 20);
    random_phase(40000, 0, 30);
    random_phase(12345, 100, 20);
    random_phase($urandom_range(1, 65535), 127, 15);
    random_phase($urandom_range(1, 65535), $urandom_range(1, 16), 60);
    random_phase(65535, 3, 55);
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    speed_i <= '0;
    turn_rate_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= utr_pkg::RegTimeStep;
    cfg_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_heading_saturation();
    test_zero_time_step();
    test_step_count_limits();
    test_random_rollouts();

    wait_drained();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/utr_pkg.sv
hdl/utr_mul.sv
hdl/utr_sincos.sv
hdl/unicycle_trajectory_rollout.sv
tb/tb.sv
